// ===== design/spr_pkg.sv =====
// Shared types and constants for the stepper position ramp.
// No dependencies.
`default_nettype none

package spr_pkg;

    typedef enum logic [1:0] {
        PA_NONE  = 2'd0,
        PA_START = 2'd1,
        PA_STOP  = 2'd2
    } t_pulse_action;

    localparam logic CFG_RATE_MAX = 1'b0;
    localparam logic CFG_RATE_MIN = 1'b1;

    localparam logic [15:0] RATE_MAX_RESET = 16'd50000;
    localparam logic [15:0] RATE_MIN_RESET = 16'd10000;
    localparam logic [15:0] RATE_NOW_RESET = 16'd300;

    // 5 * remaining distance and the ramp thresholds derived from the move length
    localparam int unsigned DIST_W = 35;

endpackage

`default_nettype wire

// ===== design/stepper_position_ramp.sv =====
// Stepper position ramp: trapezoidal rate ramp towards a commanded position.
// Depends on spr_pkg.
// A transfer passes through the input register, then the result register, which a stall can hold.
// Throughput: one tick per cycle, resolved in a single pass between the input
// register and the result register; a stalled result holds the input back.
// Reset (synchronous, active low): rate 300, position 0, default clamps, stages empty.
`default_nettype none

module stepper_position_ramp (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [31:0] i_target_position,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_position,
    output logic             o_direction,
    output logic             o_running,
    output logic [15:0]      o_rate,
    output logic             o_rate_applied,
    output logic [1:0]       o_pulse_action,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    localparam int unsigned DW = spr_pkg::DIST_W;

    // configuration
    logic [15:0] r_rate_max;
    logic [15:0] r_rate_min;

    // input stage
    logic        r_in_valid;
    logic [31:0] r_in_target;

    // block state
    logic [15:0]   r_rate_now,  n_rate_now;
    logic [15:0]   r_rate_appl, n_rate_appl;
    logic [31:0]   r_pos,       n_pos;
    logic [31:0]   r_last_tgt,  n_last_tgt;
    logic          r_dir,       n_dir;
    logic          r_run,       n_run;
    logic [DW-1:0] r_rem5,      n_rem5;   // 5 * remaining distance, one step behind
    logic [DW-1:0] r_up_thr,    n_up_thr; // 3L + 5
    logic [DW-1:0] r_dn_thr,    n_dn_thr; // 2L

    // result register
    logic                  r_out_valid;
    logic [31:0]           r_out_pos;
    logic                  r_out_dir;
    logic                  r_out_run;
    logic [15:0]           r_out_rate;
    logic                  r_out_appl;
    spr_pkg::t_pulse_action r_out_action;
    logic                  n_appl;
    spr_pkg::t_pulse_action n_action;

    logic s2_fire;

    // tick decode
    logic          rate_zero;
    logic          rate_change;
    logic          new_tgt;
    logic          at_tgt;
    logic          pos_gt;
    logic [32:0]   diff_fwd;
    logic [32:0]   diff_rev;
    logic [32:0]   len;
    logic [DW-1:0] len5;
    logic [DW-1:0] len3p5;
    logic          go_up;
    logic          go_dn;
    logic          step_dir;
    logic [15:0]   rate_up;
    logic [15:0]   rate_dn;

    assign s2_fire    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !s2_fire;

    assign rate_zero   = (r_rate_now == 16'd0);
    assign rate_change = (r_rate_now != r_rate_appl);
    assign new_tgt     = (r_in_target != r_last_tgt);
    assign at_tgt      = (r_pos == r_in_target);
    assign pos_gt      = ($signed(r_pos) > $signed(r_in_target));
    assign diff_fwd    = {r_in_target[31], r_in_target} - {r_pos[31], r_pos};
    assign diff_rev    = {r_pos[31], r_pos} - {r_in_target[31], r_in_target};
    assign len         = pos_gt ? diff_rev : diff_fwd;
    assign len5        = {len, 2'b00} + {2'b00, len};
    assign len3p5      = {1'b0, len, 1'b0} + {2'b00, len} + DW'(5);

    // on a new target the remaining distance equals the move length, so it ramps up
    assign go_up    = new_tgt || (r_rem5 > r_up_thr);
    assign go_dn    = !new_tgt && (r_rem5 <= r_dn_thr);
    assign step_dir = new_tgt ? !pos_gt : r_dir;
    assign rate_up  = (r_rate_now < r_rate_max) ? r_rate_now + 16'd1 : r_rate_max;
    assign rate_dn  = (r_rate_now > r_rate_min) ? r_rate_now - 16'd1 : r_rate_min;

    always_comb begin
        n_rate_now  = r_rate_now;
        n_rate_appl = r_rate_appl;
        n_pos       = r_pos;
        n_last_tgt  = r_last_tgt;
        n_dir       = r_dir;
        n_run       = r_run;
        n_rem5      = r_rem5;
        n_up_thr    = r_up_thr;
        n_dn_thr    = r_dn_thr;
        n_appl      = 1'b0;
        n_action    = spr_pkg::PA_NONE;
        if (rate_zero) begin
            n_action = spr_pkg::PA_NONE;
        end else if (rate_change) begin
            n_rate_appl = r_rate_now;
            n_appl      = 1'b1;
            n_action    = r_run ? spr_pkg::PA_START : spr_pkg::PA_STOP;
        end else begin
            if (new_tgt) begin
                n_dir      = !pos_gt;
                n_run      = 1'b1;
                n_action   = spr_pkg::PA_START;
                n_last_tgt = r_in_target;
                n_rem5     = len5;
                n_up_thr   = len3p5;
                n_dn_thr   = {1'b0, len, 1'b0};
            end
            if (at_tgt) begin
                n_action   = spr_pkg::PA_STOP;
                n_rate_now = r_rate_min;
                n_run      = 1'b0;
            end else begin
                if (go_up) begin
                    n_rate_now = rate_up;
                end else if (go_dn) begin
                    n_rate_now = rate_dn;
                end
                if (!new_tgt) begin
                    n_rem5 = r_rem5 - DW'(5);
                end
                n_pos = step_dir ? r_pos + 32'd1 : r_pos - 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_max   <= spr_pkg::RATE_MAX_RESET;
            r_rate_min   <= spr_pkg::RATE_MIN_RESET;
            r_in_valid   <= 1'b0;
            r_rate_now   <= spr_pkg::RATE_NOW_RESET;
            r_rate_appl  <= 16'd0;
            r_pos        <= 32'd0;
            r_last_tgt   <= 32'd0;
            r_dir        <= 1'b0;
            r_run        <= 1'b0;
            r_rem5       <= '0;
            r_up_thr     <= '0;
            r_dn_thr     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == spr_pkg::CFG_RATE_MAX) begin
                    r_rate_max <= i_cfg_data;
                end else begin
                    r_rate_min <= i_cfg_data;
                end
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (s2_fire) begin
                r_rate_now  <= n_rate_now;
                r_rate_appl <= n_rate_appl;
                r_pos       <= n_pos;
                r_last_tgt  <= n_last_tgt;
                r_dir       <= n_dir;
                r_run       <= n_run;
                r_rem5      <= n_rem5;
                r_up_thr    <= n_up_thr;
                r_dn_thr    <= n_dn_thr;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_target <= i_target_position;
        end
        if (s2_fire) begin
            r_out_pos    <= n_pos;
            r_out_dir    <= n_dir;
            r_out_run    <= n_run;
            r_out_rate   <= n_rate_now;
            r_out_appl   <= n_appl;
            r_out_action <= n_action;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_position     = r_out_pos;
    assign o_direction    = r_out_dir;
    assign o_running      = r_out_run;
    assign o_rate         = r_out_rate;
    assign o_rate_applied = r_out_appl;
    assign o_pulse_action = r_out_action;

    a_applied_has_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rate_applied) |-> (o_pulse_action != spr_pkg::PA_NONE))
        else $error("rate applied without a pulse action");

    a_rate_holds_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s2_fire |=> $stable(r_rate_now))
        else $error("rate changed without a tick");

    a_stop_at_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_fire && at_tgt && !rate_zero && !rate_change)
        |=> (!r_run && r_rate_now == $past(r_rate_min)))
        else $error("stop at target did not load minimum rate");

    a_single_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_fire |=> (r_pos == $past(r_pos) || r_pos == $past(r_pos) + 32'd1 ||
                     r_pos == $past(r_pos) - 32'd1))
        else $error("position moved by more than one step");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for stepper_position_ramp: random and directed position ticks,
// predicted results compared transfer by transfer. Depends on spr_pkg and the RTL.
module testbench;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SEGMENTS = 7;
    localparam int SEGMENT_TICKS = 150;
    localparam logic [31:0] DIRECTED_TARGETS [20] = '{
        32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'd4, 32'd4, 32'd4, 32'd4, 32'd4, 32'd4, 32'd4, 32'd4, 32'd4
    };
    localparam logic [15:0] SEG_RATE_MAX [SEGMENTS] = '{
        16'd65535, 16'd310, 16'd1000, 16'd500, 16'd65535, 16'd12, 16'd50000
    };
    localparam logic [15:0] SEG_RATE_MIN [SEGMENTS] = '{
        16'd65533, 16'd300, 16'd990, 16'd520, 16'd65535, 16'd1, 16'd10000
    };

    typedef struct packed {
        logic [31:0]            position;
        logic                   direction;
        logic                   running;
        logic [15:0]            rate;
        logic                   rate_applied;
        spr_pkg::t_pulse_action action;
    } t_tick_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [31:0] i_target_position = '0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = spr_pkg::CFG_RATE_MAX;
    logic [15:0] i_cfg_data = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [31:0] o_position;
    logic        o_direction;
    logic        o_running;
    logic [15:0] o_rate;
    logic        o_rate_applied;
    logic [1:0]  o_pulse_action;

    // predicted block state
    logic [15:0] cfg_rate_max = spr_pkg::RATE_MAX_RESET;
    logic [15:0] cfg_rate_min = spr_pkg::RATE_MIN_RESET;
    logic [15:0] rate_cur = spr_pkg::RATE_NOW_RESET;
    logic [15:0] rate_loaded = '0;
    logic [31:0] step_pos = '0;
    logic [31:0] held_target = '0;
    longint      move_len = 0;
    logic        dir_fwd = 1'b0;
    logic        moving = 1'b0;

    logic [31:0]  target_fifo [$];
    t_tick_result predicted_ticks [$];
    int           send_idle_pct = 28;
    int           recv_idle_pct = 52;
    int           mismatches = 0;
    int           cycle_count = 0;

    stepper_position_ramp dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_target_position (i_target_position),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_position        (o_position),
        .o_direction       (o_direction),
        .o_running         (o_running),
        .o_rate            (o_rate),
        .o_rate_applied    (o_rate_applied),
        .o_pulse_action    (o_pulse_action),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_tick_result advance_ramp(input logic [31:0] tgt);
        t_tick_result           r;
        spr_pkg::t_pulse_action act;
        longint                 pos_s;
        longint                 tgt_s;
        longint                 len;
        longint                 rem;
        act = spr_pkg::PA_NONE;
        r.rate_applied = 1'b0;
        if (rate_cur == '0) begin
            act = spr_pkg::PA_NONE;
        end else if (rate_cur != rate_loaded) begin
            rate_loaded = rate_cur;
            r.rate_applied = 1'b1;
            act = moving ? spr_pkg::PA_START : spr_pkg::PA_STOP;
        end else begin
            pos_s = $signed(step_pos);
            tgt_s = $signed(tgt);
            if (tgt != held_target) begin
                dir_fwd = (pos_s > tgt_s) ? 1'b0 : 1'b1;
                moving = 1'b1;
                act = spr_pkg::PA_START;
                move_len = tgt_s - pos_s;
                held_target = tgt;
            end
            if (step_pos == tgt) begin
                act = spr_pkg::PA_STOP;
                rate_cur = cfg_rate_min;
                moving = 1'b0;
            end else begin
                len = (move_len < 0) ? -move_len : move_len;
                rem = (tgt_s > pos_s) ? tgt_s - pos_s : pos_s - tgt_s;
                if (rem > len * 3 / 5) begin
                    rate_cur = (rate_cur < cfg_rate_max) ? rate_cur + 16'd1 : cfg_rate_max;
                end else if (rem < len * 2 / 5) begin
                    rate_cur = (rate_cur > cfg_rate_min) ? rate_cur - 16'd1 : cfg_rate_min;
                end
                step_pos = dir_fwd ? step_pos + 32'd1 : step_pos - 32'd1;
            end
        end
        r.position = step_pos;
        r.direction = dir_fwd;
        r.running = moving;
        r.rate = rate_cur;
        r.action = act;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // input driver: presents the oldest pending target until it transfers
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predicted_ticks.push_back(advance_ramp(i_target_position));
                void'(target_fifo.pop_front());
            end
            if (i_in_valid && o_in_stall) begin
                i_in_valid <= 1'b1;
            end else if (target_fifo.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_target_position <= target_fifo[0];
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_tick_result want;
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (predicted_ticks.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual position %0h",
                         $time, o_position);
                mismatches++;
            end else begin
                want = predicted_ticks.pop_front();
                compare_field("position", want.position, o_position);
                compare_field("direction", 32'(want.direction), 32'(o_direction));
                compare_field("running", 32'(want.running), 32'(o_running));
                compare_field("rate", 32'(want.rate), 32'(o_rate));
                compare_field("rate_applied", 32'(want.rate_applied),
                              32'(o_rate_applied));
                compare_field("pulse_action", 32'(want.action), 32'(o_pulse_action));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("stepper_position_ramp verification failed");
            $finish;
        end
    end

    task automatic drain_targets();
        while (target_fifo.size() != 0) @(negedge i_clk);
    endtask

    task automatic settle();
        while (target_fifo.size() != 0 || predicted_ticks.size() != 0) @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == spr_pkg::CFG_RATE_MAX) begin
            cfg_rate_max = value;
        end else begin
            cfg_rate_min = value;
        end
    endtask

    // mostly complete moves to a nearby target, some cut short, some far-off noise
    task automatic run_segment(input int n_ticks);
        int          made;
        int          kind;
        int          span;
        int          span_abs;
        int          reps;
        logic [31:0] tgt;
        made = 0;
        while (made < n_ticks) begin
            kind = $urandom_range(99);
            span_abs = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(14);
            span = $urandom_range(1) ? -span_abs : span_abs;
            tgt = step_pos + 32'(span);
            if (kind < 75) begin
                reps = 2 * span_abs + 4;
            end else if (kind < 90) begin
                reps = $urandom_range(2 * span_abs + 1, 1);
            end else begin
                case ($urandom_range(3))
                    0: tgt = 32'h8000_0000;
                    1: tgt = 32'h7FFF_FFFF;
                    default: tgt = $urandom();
                endcase
                reps = $urandom_range(3, 1);
            end
            repeat (reps) target_fifo.push_back(tgt);
            made += reps;
            drain_targets();
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (DIRECTED_TARGETS[k]) target_fifo.push_back(DIRECTED_TARGETS[k]);
        settle();
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 2) begin
                send_idle_pct = 52;
                recv_idle_pct = 28;
            end else if (seg == 5) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(spr_pkg::CFG_RATE_MAX, SEG_RATE_MAX[seg]);
            write_reg(spr_pkg::CFG_RATE_MIN, SEG_RATE_MIN[seg]);
            run_segment(SEGMENT_TICKS);
            settle();
        end
        // zero minimum: the stop at the end of this move leaves the rate at zero for good
        write_reg(spr_pkg::CFG_RATE_MIN, 16'd0);
        repeat (12) target_fifo.push_back(step_pos + 32'd3);
        settle();
        write_reg(spr_pkg::CFG_RATE_MAX, 16'd0);
        repeat (12) target_fifo.push_back($urandom());
        settle();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("stepper_position_ramp verification clean");
        end else begin
            $display("stepper_position_ramp verification failed");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
design/spr_pkg.sv
design/stepper_position_ramp.sv
tb/sv/testbench.sv
